>>> hdl/lsws_pkg.sv
// Shared types and constants for the LED sine wave shader.
// Holds the transfer item structs, the sequencer state type and the series constants.
// No dependencies.
`timescale 1ns / 1ps

package lsws_pkg;

    // One input item: the pixel position and the end of frame flag.
    typedef struct packed {
        logic [9:0] pixel_index;
        logic       end_of_frame;
    } t_in_item;

    // One result item: the echoed index and the shaded color.
    typedef struct packed {
        logic [9:0] pixel_out;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_out_item;

    // Configuration register indexes.
    typedef logic [2:0] t_cfg_addr;
    localparam t_cfg_addr CFG_BASE_COLOR  = 3'd0;
    localparam t_cfg_addr CFG_INTENSITY   = 3'd1;
    localparam t_cfg_addr CFG_PIXEL_PHASE = 3'd2;
    localparam t_cfg_addr CFG_PHASE_STEP  = 3'd3;
    localparam t_cfg_addr CFG_REVERSE     = 3'd4;

    // Sequencer states. Each compute state consumes the product of the
    // operands loaded when it was entered.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ANGLE,
        ST_XVAL,
        ST_XSQ,
        ST_DIV,
        ST_SPROD,
        ST_SINE,
        ST_FACTOR,
        ST_CHAN,
        ST_DONE
    } t_state;

    // Fixed point constants.
    localparam logic [30:0] Q30_ONE     = 31'd1073741824;
    localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;
    localparam logic [15:0] SINE_FLOOR  = 16'd163;
    localparam int          TURN_LIMIT  = 10;
    localparam logic [22:0] FACTOR_ONE  = 23'd4194304;

    // Series term index: terms divide by 110, 72, 42, 20 and 6 in that order.
    typedef logic [2:0] t_term;
    localparam t_term TERM_FIRST = 3'd0;
    localparam t_term TERM_LAST  = 3'd4;

    // Each division by a small constant d is a pre-shift by the power of two
    // in d, then a multiply by the rounded-up reciprocal of the odd rest and
    // a right shift. The shift is wide enough to make the quotient exact
    // for every partial product the series can produce.
    function automatic logic [1:0] term_pre(input t_term k);
        case (k)
            3'd0:    return 2'd1;
            3'd1:    return 2'd3;
            3'd2:    return 2'd1;
            3'd3:    return 2'd2;
            default: return 2'd1;
        endcase
    endfunction

    function automatic logic [31:0] term_mult(input t_term k);
        case (k)
            3'd0:    return 32'd2498890064;
            3'd1:    return 32'd954437177;
            3'd2:    return 32'd3272356036;
            3'd3:    return 32'd1717986919;
            default: return 32'd2863311531;
        endcase
    endfunction

    function automatic logic [5:0] term_shift(input t_term k);
        case (k)
            3'd0:    return 6'd37;
            3'd1:    return 6'd33;
            3'd2:    return 6'd36;
            3'd3:    return 6'd33;
            default: return 6'd33;
        endcase
    endfunction

endpackage

>>> hdl/led_sine_wave_shader.sv
// LED sine wave shader: dims a base color along a moving sine wave.
// Depends on lsws_pkg for item structs, states and series constants.
//
// Usage: one pixel item enters on the input channel (i_in_valid, o_in_stall)
// and one colored result leaves on the output channel (o_out_valid,
// i_out_stall). A transfer happens at a rising edge with valid high and
// stall low. Configuration is written through i_cfg_we, i_cfg_addr and
// i_cfg_data while the block is idle: a rule for the user, not enforced.
// One item is worked at a time by a single 32 by 32 bit multiplier that a
// small sequencer reuses: angle, radian scaling, square, the five-term sine
// series with its constant divisions, intensity and three channel scales.
// A dimmed item runs through every state; one whose base color passes
// unchanged ends after the sine, one whose dimming factor bottoms out at
// zero after the factor, and one whose index lies beyond the strip skips
// every compute state. The result lands in an output register, so the next
// item is taken while a result still waits; a result held by i_out_stall
// only blocks the following result from being written out.
// Reset clears all configuration registers, the wave offset and o_out_valid.
`timescale 1ns / 1ps

module led_sine_wave_shader #(
    parameter int NUM_PIXELS = 256,
    parameter int PHASE_BITS = 12
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  lsws_pkg::t_in_item i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output lsws_pkg::t_out_item o_out_data,
    input  logic               i_cfg_we,
    input  lsws_pkg::t_cfg_addr i_cfg_addr,
    input  logic [23:0]        i_cfg_data
);

    // Offset width: ten turns plus one step, signed.
    localparam int OW = PHASE_BITS + 6;
    // Folded quarter-turn angle width: 0 up to one full quarter.
    localparam int QW = PHASE_BITS - 1;
    localparam logic [QW-1:0] QUARTER = QW'(1) << (PHASE_BITS - 2);
    localparam logic [OW-1:0] OFS_LIMIT = OW'(lsws_pkg::TURN_LIMIT * (2 ** PHASE_BITS));
    localparam logic [OW-1:0] OFS_BOUND = OW'(lsws_pkg::TURN_LIMIT * (2 ** PHASE_BITS) + 4096);
    localparam logic [1:0] CH_LAST = 2'd2;

    // Configuration registers.
    logic [23:0] r_base_color;
    logic [8:0]  r_intensity;
    logic [11:0] r_pixel_phase;
    logic [11:0] r_phase_step;
    logic        r_reverse;

    // Sequencer and item state.
    lsws_pkg::t_state r_state, n_state;
    logic             r_mw, n_mw;
    lsws_pkg::t_term  r_term, n_term;
    logic [1:0]       r_ch, n_ch;
    logic [9:0]       r_idx, n_idx;
    logic             r_eof, n_eof;
    logic             r_neg, n_neg;
    logic [30:0]      r_x, n_x;
    logic [31:0]      r_x2, n_x2;
    logic [22:0]      r_factor, n_factor;
    logic [7:0]       r_red, n_red;
    logic [7:0]       r_green, n_green;
    logic [7:0]       r_blue, n_blue;
    logic signed [OW-1:0] r_offset, n_offset;

    // Shared multiplier operands and product.
    logic [31:0] r_opa, n_opa;
    logic [31:0] r_opb, n_opb;
    logic [63:0] r_prod;

    // Output register.
    logic                r_ov, n_ov;
    lsws_pkg::t_out_item r_out, n_out;

    // Decoded conditions shared by the next state and datapath logic.
    logic                  w_in_xfer;
    logic                  w_beyond;
    logic                  w_out_free;
    logic [PHASE_BITS-1:0] w_angle;
    logic [PHASE_BITS-3:0] w_rem;
    logic [QW-1:0]         w_q;
    logic [30:0]           w_quot;
    logic [30:0]           w_t;
    logic [31:0]           w_sprod;
    logic [31:0]           w_round;
    logic [15:0]           w_v;
    logic                  w_shade;
    logic                  w_factor_pos;
    logic [OW-1:0]         w_mag;
    logic [OW-1:0]         w_step;

    assign o_in_stall  = (r_state != lsws_pkg::ST_IDLE);
    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;

    // Handshake and condition decode.
    always_comb begin
        w_in_xfer    = i_in_valid && !o_in_stall;
        w_beyond     = ({1'b0, i_in_data.pixel_index} >= 11'(NUM_PIXELS));
        w_out_free   = !r_ov || !i_out_stall;
        w_angle      = r_prod[PHASE_BITS-1:0] + r_offset[PHASE_BITS-1:0];
        w_rem        = w_angle[PHASE_BITS-3:0];
        w_q          = w_angle[PHASE_BITS-2] ? (QUARTER - {1'b0, w_rem}) : {1'b0, w_rem};
        w_quot       = 31'(r_prod >> lsws_pkg::term_shift(r_term));
        w_t          = lsws_pkg::Q30_ONE - w_quot;
        w_sprod      = r_prod[61:30];
        w_round      = w_sprod + 32'd32768;
        w_v          = w_round[31:16];
        w_shade      = !r_neg && (w_v > lsws_pkg::SINE_FLOOR);
        w_factor_pos = (r_prod[24:0] < 25'(lsws_pkg::FACTOR_ONE));
        w_mag        = r_offset[OW-1] ? OW'(-r_offset) : OW'(r_offset);
        w_step       = {{(OW-12){1'b0}}, r_phase_step};
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            lsws_pkg::ST_IDLE: begin
                if (w_in_xfer) begin
                    n_state = w_beyond ? lsws_pkg::ST_DONE : lsws_pkg::ST_ANGLE;
                end
            end
            lsws_pkg::ST_ANGLE: begin
                if (!r_mw) n_state = lsws_pkg::ST_XVAL;
            end
            lsws_pkg::ST_XVAL: begin
                if (!r_mw) n_state = lsws_pkg::ST_XSQ;
            end
            lsws_pkg::ST_XSQ: begin
                if (!r_mw) n_state = lsws_pkg::ST_DIV;
            end
            lsws_pkg::ST_DIV: begin
                if (!r_mw) begin
                    n_state = (r_term == lsws_pkg::TERM_LAST) ? lsws_pkg::ST_SINE
                                                              : lsws_pkg::ST_SPROD;
                end
            end
            lsws_pkg::ST_SPROD: begin
                if (!r_mw) n_state = lsws_pkg::ST_DIV;
            end
            lsws_pkg::ST_SINE: begin
                if (!r_mw) n_state = w_shade ? lsws_pkg::ST_FACTOR : lsws_pkg::ST_DONE;
            end
            lsws_pkg::ST_FACTOR: begin
                if (!r_mw) n_state = w_factor_pos ? lsws_pkg::ST_CHAN : lsws_pkg::ST_DONE;
            end
            lsws_pkg::ST_CHAN: begin
                if (!r_mw && r_ch == CH_LAST) n_state = lsws_pkg::ST_DONE;
            end
            lsws_pkg::ST_DONE: begin
                if (w_out_free) n_state = lsws_pkg::ST_IDLE;
            end
            default: n_state = lsws_pkg::ST_IDLE;
        endcase
    end

    // Datapath and outputs: operand loading, result capture, offset advance.
    always_comb begin
        n_term   = r_term;
        n_ch     = r_ch;
        n_idx    = r_idx;
        n_eof    = r_eof;
        n_neg    = r_neg;
        n_x      = r_x;
        n_x2     = r_x2;
        n_factor = r_factor;
        n_red    = r_red;
        n_green  = r_green;
        n_blue   = r_blue;
        n_offset = r_offset;
        n_opa    = r_opa;
        n_opb    = r_opb;
        n_ov     = r_ov && i_out_stall;
        n_out    = r_out;
        // A product is awaited whenever the sequencer moves into or stays
        // in a compute state after acting.
        n_mw     = (n_state != lsws_pkg::ST_IDLE) && (n_state != lsws_pkg::ST_DONE)
                   && (r_state == lsws_pkg::ST_IDLE || !r_mw);

        case (r_state)
            lsws_pkg::ST_IDLE: begin
                if (w_in_xfer) begin
                    n_idx   = i_in_data.pixel_index;
                    n_eof   = i_in_data.end_of_frame;
                    n_red   = 8'd0;
                    n_green = 8'd0;
                    n_blue  = 8'd0;
                    n_opa   = 32'(i_in_data.pixel_index);
                    n_opb   = 32'(r_pixel_phase);
                end
            end
            lsws_pkg::ST_ANGLE: begin
                // Fold the angle into the first quadrant.
                if (!r_mw) begin
                    n_neg = w_angle[PHASE_BITS-1];
                    n_opa = 32'(w_q);
                    n_opb = lsws_pkg::HALF_PI_Q30;
                end
            end
            lsws_pkg::ST_XVAL: begin
                // Radians in Q30, then square.
                if (!r_mw) begin
                    n_x   = r_prod[PHASE_BITS-2 +: 31];
                    n_opa = 32'(r_prod[PHASE_BITS-2 +: 31]);
                    n_opb = 32'(r_prod[PHASE_BITS-2 +: 31]);
                end
            end
            lsws_pkg::ST_XSQ: begin
                // First series term divides x squared by its constant.
                if (!r_mw) begin
                    n_x2   = w_sprod;
                    n_term = lsws_pkg::TERM_FIRST;
                    n_opa  = w_sprod >> lsws_pkg::term_pre(lsws_pkg::TERM_FIRST);
                    n_opb  = lsws_pkg::term_mult(lsws_pkg::TERM_FIRST);
                end
            end
            lsws_pkg::ST_DIV: begin
                // Term value t = 1 - quotient; feed it to the next product.
                if (!r_mw) begin
                    n_opa = (r_term == lsws_pkg::TERM_LAST) ? 32'(r_x) : r_x2;
                    n_opb = 32'(w_t);
                end
            end
            lsws_pkg::ST_SPROD: begin
                // x squared times t, then divide by the next constant.
                if (!r_mw) begin
                    n_term = r_term + 3'd1;
                    n_opa  = w_sprod >> lsws_pkg::term_pre(r_term + 3'd1);
                    n_opb  = lsws_pkg::term_mult(r_term + 3'd1);
                end
            end
            lsws_pkg::ST_SINE: begin
                // Round the sine to Q2.14 and pick pass or dim.
                if (!r_mw) begin
                    n_red   = r_base_color[23:16];
                    n_green = r_base_color[15:8];
                    n_blue  = r_base_color[7:0];
                    n_opa   = 32'(w_v);
                    n_opb   = 32'(r_intensity);
                end
            end
            lsws_pkg::ST_FACTOR: begin
                // A factor at or below zero blanks the pixel.
                if (!r_mw) begin
                    n_factor = lsws_pkg::FACTOR_ONE - r_prod[22:0];
                    n_ch     = 2'd0;
                    n_opa    = 32'(r_base_color[23:16]);
                    n_opb    = 32'(lsws_pkg::FACTOR_ONE - r_prod[22:0]);
                    if (!w_factor_pos) begin
                        n_red   = 8'd0;
                        n_green = 8'd0;
                        n_blue  = 8'd0;
                    end
                end
            end
            lsws_pkg::ST_CHAN: begin
                // Scale one channel per product.
                if (!r_mw) begin
                    n_ch  = r_ch + 2'd1;
                    n_opb = 32'(r_factor);
                    case (r_ch)
                        2'd0: begin
                            n_red = r_prod[22 +: 8];
                            n_opa = 32'(r_base_color[15:8]);
                        end
                        2'd1: begin
                            n_green = r_prod[22 +: 8];
                            n_opa   = 32'(r_base_color[7:0]);
                        end
                        default: begin
                            n_blue = r_prod[22 +: 8];
                        end
                    endcase
                end
            end
            lsws_pkg::ST_DONE: begin
                // Hand the result to the output register; at a frame end, move or recenter the wave.
                if (w_out_free) begin
                    n_ov            = 1'b1;
                    n_out.pixel_out = r_idx;
                    n_out.red       = r_red;
                    n_out.green     = r_green;
                    n_out.blue      = r_blue;
                    if (r_eof) begin
                        if (w_mag >= OFS_LIMIT) begin
                            n_offset = '0;
                        end else if (r_reverse) begin
                            n_offset = r_offset + $signed(w_step);
                        end else begin
                            n_offset = r_offset - $signed(w_step);
                        end
                    end
                end
            end
            default: begin
                n_mw = 1'b0;
            end
        endcase
    end

    // Control registers and configuration.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= lsws_pkg::ST_IDLE;
            r_mw          <= 1'b0;
            r_ov          <= 1'b0;
            r_offset      <= '0;
            r_term        <= lsws_pkg::TERM_FIRST;
            r_ch          <= 2'd0;
            r_base_color  <= '0;
            r_intensity   <= '0;
            r_pixel_phase <= '0;
            r_phase_step  <= '0;
            r_reverse     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_mw     <= n_mw;
            r_ov     <= n_ov;
            r_offset <= n_offset;
            r_term   <= n_term;
            r_ch     <= n_ch;
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    lsws_pkg::CFG_BASE_COLOR:  r_base_color  <= i_cfg_data;
                    lsws_pkg::CFG_INTENSITY:   r_intensity   <= i_cfg_data[8:0];
                    lsws_pkg::CFG_PIXEL_PHASE: r_pixel_phase <= i_cfg_data[11:0];
                    lsws_pkg::CFG_PHASE_STEP:  r_phase_step  <= i_cfg_data[11:0];
                    lsws_pkg::CFG_REVERSE:     r_reverse     <= i_cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

    // Payload registers and the shared multiplier.
    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_eof    <= n_eof;
        r_neg    <= n_neg;
        r_x      <= n_x;
        r_x2     <= n_x2;
        r_factor <= n_factor;
        r_red    <= n_red;
        r_green  <= n_green;
        r_blue   <= n_blue;
        r_opa    <= n_opa;
        r_opb    <= n_opb;
        r_out    <= n_out;
        r_prod   <= 64'(r_opa) * 64'(r_opb);
    end

    // An accepted item starts the angle product or goes straight to output.
    a_accept_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_xfer |=> (r_state == lsws_pkg::ST_ANGLE || r_state == lsws_pkg::ST_DONE))
        else $error("accepted item did not start the sequencer");

    // The product wait lasts exactly one cycle.
    a_mul_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mw |=> !r_mw)
        else $error("multiplier wait held longer than one cycle");

    // The series index never runs past the last term.
    a_term_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_term <= lsws_pkg::TERM_LAST)
        else $error("series term index out of range");

    // A new result only comes from the finishing state.
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ov) |-> $past(r_state) == lsws_pkg::ST_DONE)
        else $error("result written outside the finishing state");

    // The wave offset stays within ten turns plus one step.
    a_offset_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mag < OFS_BOUND)
        else $error("wave offset out of bounds");

endmodule

>>> tb/sv/led_sine_wave_shader_tb.sv
// Self-checking testbench for the LED sine wave shader.
// Predicts every shaded pixel from its own copy of the registers and wave offset.
// Depends on lsws_pkg and led_sine_wave_shader.
`timescale 1ns / 1ps

module led_sine_wave_shader_tb;

    localparam int NUM_PIXELS  = 256;
    localparam int PHASE_BITS  = 12;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int MAX_REPORTS = 10;
    localparam int IDLE_PCT    = 13;

    // Fixed point constants of the sine series and the dimming rules.
    localparam longint unsigned ONE_Q30     = 64'd1073741824;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam int              SINE_CUTOFF = 163;
    localparam int              WRAP_TURNS  = 10;

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_in_valid  = 1'b0;
    lsws_pkg::t_in_item  i_in_data   = '0;
    logic                i_out_stall = 1'b0;
    logic                i_cfg_we    = 1'b0;
    lsws_pkg::t_cfg_addr i_cfg_addr  = lsws_pkg::CFG_BASE_COLOR;
    logic [23:0]         i_cfg_data  = '0;
    logic                o_in_stall;
    logic                o_out_valid;
    lsws_pkg::t_out_item o_out_data;

    // Shadow copies of the registers and the wave offset.
    logic [23:0] base_color_q   = '0;
    logic [8:0]  intensity_q    = '0;
    logic [11:0] pixel_phase_q  = '0;
    logic [11:0] phase_step_q   = '0;
    logic        reverse_q      = 1'b0;
    int          wave_offset    = 0;

    lsws_pkg::t_out_item expected_colors[$];
    int          mismatches     = 0;
    int          cycles         = 0;
    bit          src_gaps       = 1'b1;
    bit          sink_gaps      = 1'b1;
    int          sink_hold_req  = 0;
    int          sink_hold_left = 0;

    led_sine_wave_shader #(
        .NUM_PIXELS(NUM_PIXELS),
        .PHASE_BITS(PHASE_BITS)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // Watchdog on the total run length.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("led_sine_wave_shader_tb: done, errors");
            $finish;
        end
    end

    // Sine of an angle in Q2.14, using the folded Taylor series in Q30.
    function automatic int wave_sine_q14(input int unsigned angle);
        int unsigned     quarter;
        int unsigned     quad;
        int unsigned     r;
        longint unsigned q;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned t;
        int              v;
        quarter = 1 << (PHASE_BITS - 2);
        quad    = angle >> (PHASE_BITS - 2);
        r       = angle & (quarter - 1);
        q       = (quad & 1) ? longint'(quarter - r) : longint'(r);
        x       = (q * HALF_PI_Q30) >> (PHASE_BITS - 2);
        x2      = (x * x) >> 30;
        t       = ONE_Q30 - x2 / 110;
        t       = ONE_Q30 - ((x2 * t) >> 30) / 72;
        t       = ONE_Q30 - ((x2 * t) >> 30) / 42;
        t       = ONE_Q30 - ((x2 * t) >> 30) / 20;
        t       = ONE_Q30 - ((x2 * t) >> 30) / 6;
        v       = int'((((x * t) >> 30) + 32768) >> 16);
        return (quad & 2) ? -v : v;
    endfunction

    // One color channel scaled by a Q22 factor; a factor at or below zero blanks it.
    function automatic logic [7:0] scale_channel(input logic [7:0] ch, input longint factor);
        longint unsigned prod;
        if (factor <= 0)
            return 8'd0;
        prod = longint'(ch) * longint'(factor);
        return 8'(prod >> 22);
    endfunction

    // Expected shaded color of one pixel under the current wave offset.
    function automatic lsws_pkg::t_out_item shade_pixel(input lsws_pkg::t_in_item px);
        lsws_pkg::t_out_item c;
        int unsigned angle;
        int          s;
        longint      factor;
        c.pixel_out = px.pixel_index;
        c.red       = base_color_q[23:16];
        c.green     = base_color_q[15:8];
        c.blue      = base_color_q[7:0];
        if (px.pixel_index >= NUM_PIXELS) begin
            c.red   = 8'd0;
            c.green = 8'd0;
            c.blue  = 8'd0;
        end else begin
            angle = int'(px.pixel_index) * int'(pixel_phase_q) + wave_offset;
            s     = wave_sine_q14(angle & ((1 << PHASE_BITS) - 1));
            if (s > SINE_CUTOFF) begin
                factor  = (64'sd1 <<< 22) - longint'(s) * longint'(intensity_q);
                c.red   = scale_channel(c.red, factor);
                c.green = scale_channel(c.green, factor);
                c.blue  = scale_channel(c.blue, factor);
            end
        end
        return c;
    endfunction

    // Frame end: move the wave, or recenter it once it has run ten turns away.
    task automatic advance_wave_offset(input logic eof);
        int mag;
        mag = (wave_offset < 0) ? -wave_offset : wave_offset;
        if (eof) begin
            if (mag >= (WRAP_TURNS << PHASE_BITS))
                wave_offset = 0;
            else if (reverse_q)
                wave_offset = wave_offset + int'(phase_step_q);
            else
                wave_offset = wave_offset - int'(phase_step_q);
        end
    endtask

    // Register write through the plain write port, mirrored in the shadow copy.
    task automatic write_reg(input lsws_pkg::t_cfg_addr addr, input logic [23:0] value);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_addr = addr;
        i_cfg_data = value;
        case (addr)
            lsws_pkg::CFG_BASE_COLOR:  base_color_q  = value;
            lsws_pkg::CFG_INTENSITY:   intensity_q   = value[8:0];
            lsws_pkg::CFG_PIXEL_PHASE: pixel_phase_q = value[11:0];
            lsws_pkg::CFG_PHASE_STEP:  phase_step_q  = value[11:0];
            lsws_pkg::CFG_REVERSE:     reverse_q     = value[0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // Offer one pixel, hold it until the transfer, then record its expected color.
    task automatic send_pixel(input logic [9:0] idx, input logic eof);
        lsws_pkg::t_in_item px;
        px.pixel_index  = idx;
        px.end_of_frame = eof;
        @(negedge i_clk);
        while (src_gaps && $urandom_range(0, 99) < IDLE_PCT) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_in_data  = px;
        do @(posedge i_clk); while (o_in_stall);
        expected_colors.push_back(shade_pixel(px));
        advance_wave_offset(eof);
    endtask

    // Stop offering, wait for every expected color, then let the block settle.
    task automatic wait_idle(input int settle);
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (expected_colors.size() != 0)
            @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    // Receiver stall: a requested long hold-off, otherwise random stalls.
    always @(negedge i_clk) begin
        if (sink_hold_req > 0) begin
            sink_hold_left = sink_hold_req;
            sink_hold_req  = 0;
        end
        if (sink_hold_left > 0) begin
            i_out_stall = 1'b1;
            sink_hold_left--;
        end else begin
            i_out_stall = sink_gaps && ($urandom_range(0, 99) < IDLE_PCT);
        end
    end

    // Result checker: each transfer is compared with the oldest expected color.
    always @(posedge i_clk) begin
        lsws_pkg::t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_colors.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result: pixel %0d rgb %02h %02h %02h",
                             o_out_data.pixel_out, o_out_data.red,
                             o_out_data.green, o_out_data.blue);
            end else begin
                want = expected_colors.pop_front();
                if (o_out_data.pixel_out !== want.pixel_out || o_out_data.red !== want.red ||
                    o_out_data.green !== want.green || o_out_data.blue !== want.blue) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("mismatch: want %0d %02h%02h%02h, got %0d %02h%02h%02h",
                                 want.pixel_out, want.red, want.green, want.blue,
                                 o_out_data.pixel_out, o_out_data.red,
                                 o_out_data.green, o_out_data.blue);
                end
            end
        end
    end

    // Registers at reset: every color is black, in and beyond the strip.
    task automatic test_reset_state();
        send_pixel(10'd0, 1'b0);
        send_pixel(10'(NUM_PIXELS - 1), 1'b0);
        send_pixel(10'(NUM_PIXELS), 1'b1);
        send_pixel(10'd1023, 1'b1);
        wait_idle(8);
    endtask

    // Quarter turn per pixel hits zero, the peak and the trough of the wave.
    task automatic test_quadrant_peaks();
        write_reg(lsws_pkg::CFG_BASE_COLOR, 24'hFFFFFF);
        write_reg(lsws_pkg::CFG_INTENSITY, 24'd256);
        write_reg(lsws_pkg::CFG_PIXEL_PHASE, 24'd1024);
        write_reg(lsws_pkg::CFG_PHASE_STEP, 24'd0);
        write_reg(lsws_pkg::CFG_REVERSE, 24'd0);
        for (int i = 0; i < 4; i++)
            send_pixel(10'(i), 1'b0);
        wait_idle(8);
        // Intensity past full drives the factor negative; zero leaves the color.
        write_reg(lsws_pkg::CFG_INTENSITY, 24'd511);
        send_pixel(10'd1, 1'b0);
        wait_idle(8);
        write_reg(lsws_pkg::CFG_INTENSITY, 24'd0);
        send_pixel(10'd1, 1'b0);
        wait_idle(8);
    endtask

    // Small angles straddle the sine floor below which the color passes.
    task automatic test_sine_floor();
        write_reg(lsws_pkg::CFG_BASE_COLOR, 24'hA55AFF);
        write_reg(lsws_pkg::CFG_INTENSITY, 24'd256);
        write_reg(lsws_pkg::CFG_PIXEL_PHASE, 24'd1);
        for (int i = 5; i < 9; i++)
            send_pixel(10'(i), 1'b0);
        wait_idle(8);
    endtask

    // Largest reverse step until the offset passes ten turns and recenters.
    task automatic test_offset_wrap();
        write_reg(lsws_pkg::CFG_PHASE_STEP, 24'd4095);
        write_reg(lsws_pkg::CFG_REVERSE, 24'd1);
        for (int i = 0; i < 12; i++)
            send_pixel(10'(i * 20), 1'b1);
        wait_idle(8);
    endtask

    // Long receiver hold-off while pixels keep coming, so the input stalls.
    task automatic test_backpressure();
        src_gaps      = 1'b0;
        sink_hold_req = 400;
        for (int i = 0; i < 24; i++)
            send_pixel(10'($urandom_range(0, NUM_PIXELS - 1)), 1'($urandom_range(0, 1)));
        wait_idle(8);
        src_gaps = 1'b1;
    endtask

    // Register value: zero, all ones of the field, or random within it.
    function automatic logic [23:0] pick_value(input logic [23:0] top);
        case ($urandom_range(0, 4))
            0:       return 24'd0;
            1:       return top;
            default: return 24'($urandom_range(0, top));
        endcase
    endfunction

    // Random settings per phase; mostly ordered frames, some stray pixels.
    task automatic test_random_frames(input int phases, input int per_phase);
        int sent;
        int len;
        int first;
        for (int p = 0; p < phases; p++) begin
            write_reg(lsws_pkg::CFG_BASE_COLOR, pick_value(24'hFFFFFF));
            write_reg(lsws_pkg::CFG_INTENSITY, pick_value(24'd511));
            write_reg(lsws_pkg::CFG_PIXEL_PHASE, pick_value(24'd4095));
            write_reg(lsws_pkg::CFG_PHASE_STEP, pick_value(24'd4095));
            write_reg(lsws_pkg::CFG_REVERSE, 24'($urandom_range(0, 1)));
            src_gaps  = (p != 3);
            sink_gaps = (p != 3);
            sent = 0;
            while (sent < per_phase) begin
                if ($urandom_range(0, 9) < 8) begin
                    len   = $urandom_range(1, 24);
                    first = $urandom_range(0, NUM_PIXELS - len);
                    for (int i = 0; i < len; i++)
                        send_pixel(10'(first + i), i == len - 1);
                    sent += len;
                end else begin
                    send_pixel(10'($urandom_range(0, 1023)), 1'($urandom_range(0, 1)));
                    sent++;
                end
            end
            wait_idle(8);
        end
        src_gaps  = 1'b1;
        sink_gaps = 1'b1;
    endtask

    // Test sequence.
    initial begin
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_state();
        test_quadrant_peaks();
        test_sine_floor();
        test_offset_wrap();
        test_backpressure();
        test_random_frames(16, 100);

        wait_idle(60);
        if (mismatches == 0)
            $display("led_sine_wave_shader_tb: done, clean");
        else
            $display("led_sine_wave_shader_tb: done, errors");
        $finish;
    end

endmodule
